[sv/tmff_pkg.sv]
// Shared types and constants for the timestamp merge with forward fill.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tmff_pkg;
   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ADVANCE = 2'd1,
      MODE_REWIND  = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_DATA  = 2'd1,
      ST_FULL     = 2'd2,
      ST_ORDER    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FETCH,
      S_WAIT,
      S_EMIT,
      S_SINGLE
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;
      logic rewind;
      logic clear;
      logic scan_start;
      logic scan_step;
      logic fetch;
      logic capture;
      logic emit;
      logic emit_single;
      logic next_sym;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
      logic any;
      logic last_sym;
   } stat_type;

   localparam logic [63:0] TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TIME_MIN = 64'h8000_0000_0000_0000;
endpackage
`default_nettype wire

[sv/tmff_ctrl.sv]
// Controller state machine for the timestamp merge.
// Depends on tmff_pkg; drives commands into tmff_datapath.
`timescale 1ns / 1ps
`default_nettype none
module tmff_ctrl
   import tmff_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic     out_busy,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   state_type state_ff, state_in;

   // Hold the state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request at a time.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = out_busy;
            if (req_valid && !out_busy) begin
               unique case (mode_type'(req_mode))
                  MODE_LOAD: begin
                     cmd.load = 1'b1;
                     state_in = S_SINGLE;
                  end
                  MODE_ADVANCE: begin
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
                  MODE_REWIND: cmd.rewind = 1'b1;
                  MODE_CLEAR:  cmd.clear  = 1'b1;
                  default: ;
               endcase
            end
         end
         S_SINGLE: begin
            if (!out_busy) begin
               cmd.emit_single = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.any) begin
               state_in = S_SINGLE;
            end else begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.capture = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_busy) begin
               cmd.emit = 1'b1;
               if (stat.last_sym) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_sym = 1'b1;
                  state_in = S_FETCH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

[sv/tmff_datapath.sv]
// Datapath: bar memory, per-symbol counters, head scan and held bars.
// Depends on tmff_pkg; commanded by tmff_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module tmff_datapath
   import tmff_pkg::*;
#(
   parameter int SYMBOL_COUNT    = 8,
   parameter int BARS_PER_SYMBOL = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire logic [3:0]  csr_symbols,
   input  wire logic [2:0]  req_symbol,
   input  wire logic [63:0] req_bar_time,
   input  wire logic [63:0] req_open_price,
   input  wire logic [63:0] req_high_price,
   input  wire logic [63:0] req_low_price,
   input  wire logic [63:0] req_close_price,
   input  wire logic [31:0] req_traded_volume,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_out_symbol,
   output logic             rsp_updated,
   output logic [63:0]      rsp_out_time,
   output logic [63:0]      rsp_out_open,
   output logic [63:0]      rsp_out_high,
   output logic [63:0]      rsp_out_low,
   output logic [63:0]      rsp_out_close,
   output logic [31:0]      rsp_out_volume,
   output logic             rsp_last
);
   localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int BW = $clog2(BARS_PER_SYMBOL);
   localparam int CW = BW + 1;
   localparam int AW = SW + BW;
   localparam int DEPTH = SYMBOL_COUNT << BW;
   localparam int ACT = (SYMBOL_COUNT < 8) ? SYMBOL_COUNT : 8;
   localparam int DW = 5 * 64 + 32;

   // Bar memory, one word per bar.
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en;

   logic [CW-1:0] fill_ff [SYMBOL_COUNT];
   logic [CW-1:0] rpos_ff [SYMBOL_COUNT];
   logic [63:0]   last_ff [SYMBOL_COUNT];
   logic [DW-1:0] held_ff [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] upd_ff;

   logic [SW-1:0] sym_ff, scan_sym;
   logic [3:0]    n_act;
   logic [3:0]    scan_ff;
   logic          rd_pend_ff;
   logic [63:0]   best_ff;
   logic          any_ff;
   logic          match;

   logic          in_range;
   logic [SW-1:0] lsym;
   logic          full, order_bad;
   logic [1:0]    load_st_ff;
   logic [2:0]    load_sym_ff;

   logic          out_v_ff;
   logic [1:0]    o_st_ff;
   logic [2:0]    o_sym_ff;
   logic          o_upd_ff, o_last_ff;
   logic [DW-1:0] o_bar_ff;

   // Saturate the active symbol count.
   always_comb begin
      if (csr_symbols > 4'(ACT)) begin
         n_act = 4'(ACT);
      end else begin
         n_act = csr_symbols;
      end
   end

   // Classify a load against the symbol's fill and last time.
   assign in_range  = ({29'd0, req_symbol} < 32'(SYMBOL_COUNT));
   assign lsym      = SW'(req_symbol);
   assign full      = !in_range || (fill_ff[lsym] >= CW'(BARS_PER_SYMBOL));
   assign order_bad = $signed(req_bar_time) < $signed(last_ff[lsym]);
   assign wr_en     = cmd.load && !full && !order_bad;
   assign wr_addr   = {lsym, fill_ff[lsym][BW-1:0]};

   // Select the symbol whose head is read: scan index or emit index.
   assign scan_sym = cmd.scan_start ? '0 : SW'(scan_ff);
   assign rd_addr  = cmd.fetch ? {sym_ff, rpos_ff[sym_ff][BW-1:0]}
                               : {scan_sym, rpos_ff[scan_sym][BW-1:0]};

   // Write and read the bar memory.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_bar_time, req_open_price, req_high_price,
                          req_low_price, req_close_price, req_traded_volume};
      end
      rd_ff <= mem[rd_addr];
   end

   assign match = rpos_ff[sym_ff] < fill_ff[sym_ff]
                  && rd_ff[DW-1 -: 64] == best_ff;

   assign stat.scan_done = !rd_pend_ff && ({28'd0, scan_ff} >= 32'(n_act));
   assign stat.any       = any_ff;
   assign stat.last_sym  = ({28'd0, 4'(sym_ff)} + 32'd1) >= 32'(n_act);

   // Per-symbol counters and held bars.
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            fill_ff[i] <= '0;
            rpos_ff[i] <= '0;
            last_ff[i] <= TIME_MIN;
            held_ff[i] <= '0;
         end
      end else if (cmd.rewind) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            rpos_ff[i] <= '0;
            held_ff[i] <= '0;
         end
      end else begin
         if (wr_en) begin
            fill_ff[lsym] <= fill_ff[lsym] + CW'(1);
            last_ff[lsym] <= req_bar_time;
         end
         if (cmd.capture && match) begin
            held_ff[sym_ff] <= rd_ff;
            rpos_ff[sym_ff] <= rpos_ff[sym_ff] + CW'(1);
         end
      end
   end

   // Scan heads for the earliest time, one symbol a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         rd_pend_ff <= 1'b0;
         sym_ff     <= '0;
         any_ff     <= 1'b0;
         best_ff    <= TIME_MAX;
         upd_ff     <= '0;
      end else begin
         if (cmd.scan_start) begin
            scan_ff    <= 4'd0;
            rd_pend_ff <= 1'b0;
            any_ff     <= 1'b0;
            best_ff    <= TIME_MAX;
            sym_ff     <= '0;
         end else if (cmd.scan_step) begin
            // Issue the next read, compare the previous.
            if ({28'd0, scan_ff} < 32'(n_act)) begin
               scan_ff    <= scan_ff + 4'd1;
               rd_pend_ff <= 1'b1;
               sym_ff     <= SW'(scan_ff);
            end else begin
               rd_pend_ff <= 1'b0;
               sym_ff     <= '0;
            end
            if (rd_pend_ff && rpos_ff[sym_ff] < fill_ff[sym_ff]) begin
               any_ff <= 1'b1;
               if ($signed(rd_ff[DW-1 -: 64]) < $signed(best_ff)) begin
                  best_ff <= rd_ff[DW-1 -: 64];
               end
            end
         end
         if (cmd.capture) begin
            upd_ff[sym_ff] <= match;
         end
         if (cmd.next_sym) begin
            sym_ff <= sym_ff + SW'(1);
         end
      end
   end

   // Keep the load result until it is emitted; a no-data result shares it.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         load_st_ff  <= full ? ST_FULL : (order_bad ? ST_ORDER : ST_OK);
         load_sym_ff <= req_symbol;
      end else if (cmd.scan_start) begin
         load_st_ff  <= ST_NO_DATA;
         load_sym_ff <= '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_single) begin
         out_v_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_single) begin
         o_st_ff   <= load_st_ff;
         o_sym_ff  <= load_sym_ff;
         o_upd_ff  <= 1'b0;
         o_bar_ff  <= '0;
         o_last_ff <= 1'b1;
      end else if (cmd.emit) begin
         o_st_ff   <= ST_OK;
         o_sym_ff  <= 3'(sym_ff);
         o_upd_ff  <= upd_ff[sym_ff];
         o_bar_ff  <= held_ff[sym_ff];
         o_last_ff <= stat.last_sym;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_status     = o_st_ff;
   assign rsp_out_symbol = o_sym_ff;
   assign rsp_updated    = o_upd_ff;
   assign rsp_out_time   = o_bar_ff[DW-1 -: 64];
   assign rsp_out_open   = o_bar_ff[DW-65 -: 64];
   assign rsp_out_high   = o_bar_ff[DW-129 -: 64];
   assign rsp_out_low    = o_bar_ff[DW-193 -: 64];
   assign rsp_out_close  = o_bar_ff[DW-257 -: 64];
   assign rsp_out_volume = o_bar_ff[31:0];
   assign rsp_last       = o_last_ff;
endmodule
`default_nettype wire

[sv/timestamp_merge_forward_fill.sv]
// Timestamp merge with forward fill: one request at a time.
// A load gives one result; rewind and clear give none. An advance scans the
// n active heads (one memory read a cycle); if no head holds data it gives
// one no-data result, else it fetches and emits one result per symbol.
// Reset (synchronous) empties all stores and held bars at once; no sweep;
// the symbol count returns to 8.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_merge_forward_fill
   import tmff_pkg::*;
#(
   parameter int SYMBOL_COUNT    = 8,
   parameter int BARS_PER_SYMBOL = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_symbol,
   input  wire logic [63:0] req_bar_time,
   input  wire logic [63:0] req_open_price,
   input  wire logic [63:0] req_high_price,
   input  wire logic [63:0] req_low_price,
   input  wire logic [63:0] req_close_price,
   input  wire logic [31:0] req_traded_volume,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_out_symbol,
   output logic             rsp_updated,
   output logic [63:0]      rsp_out_time,
   output logic [63:0]      rsp_out_open,
   output logic [63:0]      rsp_out_high,
   output logic [63:0]      rsp_out_low,
   output logic [63:0]      rsp_out_close,
   output logic [31:0]      rsp_out_volume,
   output logic             rsp_last
);
   logic [3:0] symbols_ff;
   cmd_type    cmd;
   stat_type   stat;
   logic       out_busy;

   // Hold the symbol count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_ff <= 4'd8;
      end else if (csr_we) begin
         symbols_ff <= csr_wdata;
      end
   end

   assign out_busy = rsp_valid && rsp_stall;

   tmff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .out_busy  (out_busy),
      .stat      (stat),
      .cmd       (cmd)
   );

   tmff_datapath #(
      .SYMBOL_COUNT    (SYMBOL_COUNT),
      .BARS_PER_SYMBOL (BARS_PER_SYMBOL)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_symbols       (symbols_ff),
      .req_symbol        (req_symbol),
      .req_bar_time      (req_bar_time),
      .req_open_price    (req_open_price),
      .req_high_price    (req_high_price),
      .req_low_price     (req_low_price),
      .req_close_price   (req_close_price),
      .req_traded_volume (req_traded_volume),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_symbol    (rsp_out_symbol),
      .rsp_updated       (rsp_updated),
      .rsp_out_time      (rsp_out_time),
      .rsp_out_open      (rsp_out_open),
      .rsp_out_high      (rsp_out_high),
      .rsp_out_low       (rsp_out_low),
      .rsp_out_close     (rsp_out_close),
      .rsp_out_volume    (rsp_out_volume),
      .rsp_last          (rsp_last)
   );

`ifndef SYNTH
   // A new result is never issued over one still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(cmd.emit || cmd.emit_single))
      else $error("result overwritten while stalled");
   // At most one of load, rewind, clear, scan start, emit and single emit is issued per cycle.
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.rewind, cmd.clear, cmd.scan_start,
                  cmd.emit, cmd.emit_single}) <= 1)
      else $error("conflicting commands");
   // A result with a status other than OK (no data, full, order) is always the final one.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_last)
      else $error("error result not last");
`endif
endmodule
`default_nettype wire
